// ----- design/msc_pkg.sv -----
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants
// Field widths, register indexes, reset values and the segment decode
// table of the multiplexed seven-segment counter.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

  // Default build parameters
  localparam int unsigned DIGIT_COUNT_DEF = 4;
  localparam int unsigned TIMER_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MAX_DIGITS = 8;

  // Register reset values (full width, truncated to the timer width)
  localparam logic [CFG_DATA_W-1:0] SCAN_PERIOD_RST  = 32'd40000;
  localparam logic [CFG_DATA_W-1:0] COUNT_PERIOD_RST = 32'd40000000;
  localparam logic [CFG_DATA_W-1:0] BLINK_PERIOD_RST = 32'd20000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_PERIOD  = 8'd0,
    CFG_COUNT_PERIOD = 8'd1,
    CFG_BLINK_PERIOD = 8'd2
  } cfg_reg_e;

  typedef logic [3:0] bcd_t;

  // Seven-segment pattern for a BCD digit; non-decimal codes show zero.
  function automatic logic [SEG_W-1:0] seg_decode(input bcd_t digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h7E;
      4'd1:    seg = 8'h0C;
      4'd2:    seg = 8'hB6;
      4'd3:    seg = 8'h9E;
      4'd4:    seg = 8'hCC;
      4'd5:    seg = 8'hDA;
      4'd6:    seg = 8'hFA;
      4'd7:    seg = 8'h4E;
      4'd8:    seg = 8'hFE;
      4'd9:    seg = 8'hCE;
      default: seg = 8'h7E;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ----- design/msc_if.sv -----
// ----------------------------------------------------------------------------
// msc_if: channel interfaces
// Tick input channel, display result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface msc_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface msc_out_if;
  logic                        valid;
  logic                        ready;
  logic [msc_pkg::SEG_W-1:0]   segments;
  logic [msc_pkg::SEL_W-1:0]   digit_select;
  logic                        colon_on;
  logic [msc_pkg::COUNT_W-1:0] shown_count;
  modport source (output valid, output segments, output digit_select,
                  output colon_on, output shown_count, input ready);
  modport sink   (input valid, input segments, input digit_select,
                  input colon_on, input shown_count, output ready);
endinterface

interface msc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [msc_pkg::CFG_IDX_W-1:0]  index;
  logic [msc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/msc_timer.sv -----
// ----------------------------------------------------------------------------
// msc_timer: periodic tick timer
// Counts enabled ticks and fires once every period ticks. A zero period
// fires on every tick.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_timer #(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [TIMER_WIDTH-1:0] period_i,
  output logic                        fire_o
);

  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [TIMER_WIDTH:0]   next_val;
  logic [TIMER_WIDTH-1:0] period_eff;
  logic                   wrap;

  always_comb begin
    next_val   = {1'b0, timer_q} + {{TIMER_WIDTH{1'b0}}, 1'b1};
    period_eff = (period_i == '0) ? {{(TIMER_WIDTH-1){1'b0}}, 1'b1} : period_i;
    // also catches a timer left above a lowered period
    wrap       = next_val >= {1'b0, period_eff};
    fire_o     = en_i & wrap;
    timer_d    = timer_q;
    if (en_i) begin
      timer_d = wrap ? '0 : next_val[TIMER_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
    end else begin
      timer_q <= timer_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/msc_bcd_counter.sv -----
// ----------------------------------------------------------------------------
// msc_bcd_counter: decimal display count
// BCD digit counter with a binary shadow of the shown value. Outputs the
// post-increment state so the result stage can load it in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_bcd_counter #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             inc_i,
  output msc_pkg::bcd_t [DIGIT_COUNT-1:0]       digits_d_o,
  output logic [msc_pkg::COUNT_W-1:0]           value_d_o
);

  import msc_pkg::*;

  bcd_t [DIGIT_COUNT-1:0] digits_q, digits_d;
  logic [COUNT_W-1:0]     value_q, value_d;
  logic [DIGIT_COUNT:0]   carry;

  // Ripple carry over the digits, units first (index 0).
  always_comb begin
    carry[0] = inc_i;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digits_d[i]  = digits_q[i];
      carry[i+1]   = 1'b0;
      if (carry[i]) begin
        if (digits_q[i] >= 4'd9) begin
          digits_d[i] = '0;
          carry[i+1]  = 1'b1;
        end else begin
          digits_d[i] = digits_q[i] + 4'd1;
        end
      end
    end
    // shadow tracks the decimal value and clears with the top digit carry
    if (carry[DIGIT_COUNT]) begin
      value_d = '0;
    end else begin
      value_d = value_q + {{(COUNT_W-1){1'b0}}, inc_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      value_q  <= '0;
    end else begin
      digits_q <= digits_d;
      value_q  <= value_d;
    end
  end

  assign digits_d_o = digits_d;
  assign value_d_o  = value_d;

endmodule

`default_nettype wire

// ----- design/msc_display.sv -----
// ----------------------------------------------------------------------------
// msc_display: digit mux and segment decode
// Picks the scanned digit, most significant at position zero, and forms
// the segment pattern and the one-hot digit select.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_display #(
  parameter int unsigned DIGIT_COUNT = 4,
  localparam int unsigned POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  wire logic [POS_W-1:0]                 pos_i,
  input  wire msc_pkg::bcd_t [DIGIT_COUNT-1:0]  digits_i,
  output logic [msc_pkg::SEG_W-1:0]             segments_o,
  output logic [msc_pkg::SEL_W-1:0]             digit_select_o
);

  import msc_pkg::*;

  logic [POS_W-1:0]      digit_idx;
  logic [MAX_DIGITS-1:0] sel_wide;

  always_comb begin
    digit_idx      = POS_W'(DIGIT_COUNT - 1) - pos_i;
    segments_o     = seg_decode(digits_i[digit_idx]);
    sel_wide       = MAX_DIGITS'(1) << pos_i;
    digit_select_o = sel_wide[SEL_W-1:0];
  end

endmodule

`default_nettype wire

// ----- design/multiplexed_seven_segment_counter.sv -----
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_counter: scanned 4-digit display counter
// Three periodic timers drive digit scan, a decimal count and a blinking
// colon; each transfer returns the display drive after its tick.
// ----------------------------------------------------------------------------
// Each input transfer carries one base tick (tick=1) or a plain sample
// (tick=0) and yields exactly one result transfer describing the display
// after that tick: segment pattern of the scanned digit, one-hot digit
// select (1 = thousands ... 8 = units), colon lamp and the decimal count.
// One transfer is taken every clock cycle while ready; the result appears
// in the next cycle from the output register. Ready is high whenever the
// output register is empty or being drained, so throughput is set only by
// the sink. Each timer fires once every period ticks (period 0 acts as 1,
// periods are truncated to TIMER_WIDTH bits). Registers: 0 scan_period,
// 1 count_period, 2 blink_period; writes to other indexes are dropped.
// Write registers only while no result is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_counter #(
  parameter int unsigned DIGIT_COUNT = msc_pkg::DIGIT_COUNT_DEF,
  parameter int unsigned TIMER_WIDTH = msc_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  msc_in_if.sink    in_i,
  msc_out_if.source out_o,
  msc_cfg_if.sink   cfg_i
);

  import msc_pkg::*;

  localparam int unsigned POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers (always ready)
  // --------------------------------------------------------------------------
  logic [TIMER_WIDTH-1:0] scan_period_q, count_period_q, blink_period_q;
  logic                   cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_period_q  <= TIMER_WIDTH'(SCAN_PERIOD_RST);
      count_period_q <= TIMER_WIDTH'(COUNT_PERIOD_RST);
      blink_period_q <= TIMER_WIDTH'(BLINK_PERIOD_RST);
    end else if (cfg_wr) begin
      unique case (cfg_i.index)
        CFG_SCAN_PERIOD:  scan_period_q  <= cfg_i.data[TIMER_WIDTH-1:0];
        CFG_COUNT_PERIOD: count_period_q <= cfg_i.data[TIMER_WIDTH-1:0];
        CFG_BLINK_PERIOD: blink_period_q <= cfg_i.data[TIMER_WIDTH-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: single output register, ready passes through when draining
  // --------------------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  logic in_acc, step;

  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign in_acc      = in_i.valid & in_i.ready;
  assign step        = in_acc & in_i.tick;
  assign out_valid_d = in_acc | (out_valid_q & ~out_o.ready);

  // --------------------------------------------------------------------------
  // Timers
  // --------------------------------------------------------------------------
  logic scan_fire, count_fire, blink_fire;

  msc_timer #(.TIMER_WIDTH(TIMER_WIDTH)) u_scan_timer (
    .clk_i, .rst_ni, .en_i(step), .period_i(scan_period_q), .fire_o(scan_fire)
  );

  msc_timer #(.TIMER_WIDTH(TIMER_WIDTH)) u_count_timer (
    .clk_i, .rst_ni, .en_i(step), .period_i(count_period_q), .fire_o(count_fire)
  );

  msc_timer #(.TIMER_WIDTH(TIMER_WIDTH)) u_blink_timer (
    .clk_i, .rst_ni, .en_i(step), .period_i(blink_period_q), .fire_o(blink_fire)
  );

  // --------------------------------------------------------------------------
  // Scan position and colon lamp
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] pos_q, pos_d;
  logic             colon_q, colon_d;

  always_comb begin
    pos_d = pos_q;
    if (scan_fire) begin
      // wraps from the units digit straight back to thousands
      pos_d = (pos_q >= POS_W'(DIGIT_COUNT - 1)) ? '0 : pos_q + POS_W'(1);
    end
    colon_d = colon_q ^ blink_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      colon_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      colon_q <= colon_d;
    end
  end

  // --------------------------------------------------------------------------
  // Decimal count
  // --------------------------------------------------------------------------
  bcd_t [DIGIT_COUNT-1:0] digits_d;
  logic [COUNT_W-1:0]     value_d;

  msc_bcd_counter #(.DIGIT_COUNT(DIGIT_COUNT)) u_counter (
    .clk_i, .rst_ni, .inc_i(count_fire), .digits_d_o(digits_d), .value_d_o(value_d)
  );

  // --------------------------------------------------------------------------
  // Display decode of the post-tick state
  // --------------------------------------------------------------------------
  logic [SEG_W-1:0] seg_d;
  logic [SEL_W-1:0] sel_d;

  msc_display #(.DIGIT_COUNT(DIGIT_COUNT)) u_display (
    .pos_i(pos_d), .digits_i(digits_d), .segments_o(seg_d), .digit_select_o(sel_d)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [SEG_W-1:0]   seg_q;
  logic [SEL_W-1:0]   sel_q;
  logic               colon_out_q;
  logic [COUNT_W-1:0] count_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seg_q       <= seg_d;
      sel_q       <= sel_d;
      colon_out_q <= colon_d;
      count_out_q <= value_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.segments     = seg_q;
  assign out_o.digit_select = sel_q;
  assign out_o.colon_on     = colon_out_q;
  assign out_o.shown_count  = count_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_acc_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.valid)
    else $error("accepted transfer produced no result");

  a_sample_holds_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.tick) |=> $stable(pos_q) && $stable(colon_q))
    else $error("sample transfer changed display state");

  a_select_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (DIGIT_COUNT > SEL_W) || $onehot(out_o.digit_select))
    else $error("digit select not one-hot");

  a_no_fire_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |-> !scan_fire && !count_fire && !blink_fire)
    else $error("timer event without a tick");

endmodule

`default_nettype wire

// ----- tb/multiplexed_seven_segment_counter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_counter_checker: display scoreboard
// Watches the tick, display and register channels, keeps its own copy of the
// three timers, scan position, BCD count and colon lamp, and compares every
// display transfer field by field against the oldest predicted display.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_counter_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  msc_in_if           in_mon_i,
  msc_out_if          out_mon_i,
  msc_cfg_if          cfg_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import msc_pkg::*;

  localparam int unsigned DIGITS = DIGIT_COUNT_DEF;

  // Segment patterns for decimal digits 0..9
  localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
    8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC, 8'hDA, 8'hFA, 8'h4E, 8'hFE, 8'hCE
  };

  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic [SEL_W-1:0]   digit_select;
    logic               colon_on;
    logic [COUNT_W-1:0] shown_count;
  } display_t;

  logic [CFG_DATA_W-1:0] scan_len, count_len, blink_len;
  logic [CFG_DATA_W-1:0] scan_tmr, count_tmr, blink_tmr;
  logic [1:0]            scan_pos;
  bcd_t                  count_bcd [DIGITS];  // index 0 is the units digit
  logic                  colon_lit;
  display_t              display_due [$];
  int unsigned           fault_tally;

  // Next timer value; wraps to zero when the period is reached (0 acts as 1).
  function automatic logic [CFG_DATA_W-1:0] timer_next(input logic [CFG_DATA_W-1:0] tmr,
                                                       input logic [CFG_DATA_W-1:0] period);
    logic [CFG_DATA_W:0] lim;
    logic [CFG_DATA_W:0] nxt;
    lim = (period == '0) ? (CFG_DATA_W+1)'(1) : {1'b0, period};
    nxt = {1'b0, tmr} + (CFG_DATA_W+1)'(1);
    return (nxt >= lim) ? '0 : nxt[CFG_DATA_W-1:0];
  endfunction

  task automatic advance_display(input logic tick);
    logic carry;
    if (tick) begin
      scan_tmr = timer_next(scan_tmr, scan_len);
      if (scan_tmr == '0) begin
        scan_pos = (scan_pos == 2'(DIGITS - 1)) ? '0 : scan_pos + 2'd1;
      end
      count_tmr = timer_next(count_tmr, count_len);
      if (count_tmr == '0) begin
        carry = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
          if (carry) begin
            if (count_bcd[i] == 4'd9) begin
              count_bcd[i] = '0;
            end else begin
              count_bcd[i] = count_bcd[i] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
      blink_tmr = timer_next(blink_tmr, blink_len);
      if (blink_tmr == '0) colon_lit = ~colon_lit;
    end
  endtask

  function automatic display_t predict_display();
    display_t    d;
    int unsigned value;
    d.segments     = SEG_LUT[count_bcd[DIGITS - 1 - scan_pos]];
    d.digit_select = SEL_W'(1) << scan_pos;
    d.colon_on     = colon_lit;
    value = 0;
    for (int i = DIGITS - 1; i >= 0; i--) value = value * 10 + count_bcd[i];
    d.shown_count  = value[COUNT_W-1:0];
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    display_t got;
    display_t want;
    if (!rst_ni) begin
      scan_len  = SCAN_PERIOD_RST;
      count_len = COUNT_PERIOD_RST;
      blink_len = BLINK_PERIOD_RST;
      scan_tmr  = '0;
      count_tmr = '0;
      blink_tmr = '0;
      scan_pos  = '0;
      for (int i = 0; i < DIGITS; i++) count_bcd[i] = '0;
      colon_lit = 1'b0;
      display_due.delete();
      fault_tally = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          CFG_SCAN_PERIOD:  scan_len  = cfg_mon_i.data;
          CFG_COUNT_PERIOD: count_len = cfg_mon_i.data;
          CFG_BLINK_PERIOD: blink_len = cfg_mon_i.data;
          default: ;  // unmapped index, dropped
        endcase
      end

      // Retire before predicting: a display leaves after the cycle of its tick.
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.segments     = out_mon_i.segments;
        got.digit_select = out_mon_i.digit_select;
        got.colon_on     = out_mon_i.colon_on;
        got.shown_count  = out_mon_i.shown_count;
        if (display_due.size() == 0) begin
          $error("display transfer with none expected: seg %h sel %h colon %b count %0d",
                 got.segments, got.digit_select, got.colon_on, got.shown_count);
          fault_tally++;
        end else begin
          want = display_due.pop_front();
          if (got.segments !== want.segments) begin
            $error("segments: expected %h, actual %h", want.segments, got.segments);
            fault_tally++;
          end
          if (got.digit_select !== want.digit_select) begin
            $error("digit_select: expected %h, actual %h", want.digit_select, got.digit_select);
            fault_tally++;
          end
          if (got.colon_on !== want.colon_on) begin
            $error("colon_on: expected %b, actual %b", want.colon_on, got.colon_on);
            fault_tally++;
          end
          if (got.shown_count !== want.shown_count) begin
            $error("shown_count: expected %0d, actual %0d", want.shown_count, got.shown_count);
            fault_tally++;
          end
        end
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        advance_display(in_mon_i.tick);
        display_due.push_back(predict_display());
      end

      mismatch_count_o <= fault_tally;
      pending_o <= display_due.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/multiplexed_seven_segment_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_counter_tb: counter display testbench
// Drives base ticks and period writes into the counter with random input
// gaps and output stalls; the checker predicts each display transfer and
// this top gives the verdict once all displays have drained.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_counter_tb;
  import msc_pkg::*;

  // Longest run of cycles with no transfer on any channel before giving up.
  // Normal worst case is the longest input gap plus a drain and settle pause.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Result register is one deep; a few extra cycles after the last display.
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 210;
  // Items sent back to back at the end of the run.
  localparam int unsigned TAIL_ITEMS     = 50;

  // Register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_UNUSED = 8'd3;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_TOP    = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] PERIOD_MAX     = '1;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          quiet_tail = 1'b0;  // set for the last part: no stalls, no gaps
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned stall_cycles = 0;

  msc_in_if  tick_ch ();
  msc_out_if disp_ch ();
  msc_cfg_if cfg_ch ();

  multiplexed_seven_segment_counter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_ch),
    .out_o  (disp_ch),
    .cfg_i  (cfg_ch)
  );

  multiplexed_seven_segment_counter_checker scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (tick_ch),
    .out_mon_i        (disp_ch),
    .cfg_mon_i        (cfg_ch),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((tick_ch.valid && tick_ch.ready) || (disp_ch.valid && disp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Display sink: ready runs broken by random stall bursts,
  // none once the quiet tail starts.
  initial begin
    disp_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        disp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      disp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // One tick transfer. Valid is left high so back-to-back items stream;
  // returns at the edge where the transfer happened.
  task automatic send_item(input logic tick_val);
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= tick_val;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
  endtask

  task automatic pause_input(input int unsigned cycles);
    tick_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop the tick stream and wait until every predicted display is out.
  // The first edge lets the checker count the last transfer before we look.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  // Idle the block, then write the selected periods and one write to an
  // unmapped index that must have no effect.
  task automatic load_periods(input logic [2:0] pick,
                              input logic [CFG_DATA_W-1:0] scan_len,
                              input logic [CFG_DATA_W-1:0] count_len,
                              input logic [CFG_DATA_W-1:0] blink_len,
                              input logic [CFG_IDX_W-1:0] junk_idx);
    drain();
    if (pick[0]) write_reg(CFG_SCAN_PERIOD, scan_len);
    if (pick[1]) write_reg(CFG_COUNT_PERIOD, count_len);
    if (pick[2]) write_reg(CFG_BLINK_PERIOD, blink_len);
    write_reg(junk_idx, $urandom());
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly short periods so events fire often; zero, one, random wide values
  // and the maximum show up too.
  function automatic logic [CFG_DATA_W-1:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 1;
      2, 3, 4: return $urandom_range(2, 8);
      5:       return $urandom_range(9, 60);
      6:       return $urandom();
      default: return PERIOD_MAX;
    endcase
  endfunction

  // Random items, three ticks to one plain sample, with optional input gaps.
  task automatic run_items(input int unsigned count, input bit gaps);
    for (int unsigned n = 0; n < count; n++) begin
      if (gaps && $urandom_range(0, 11) == 0) pause_input($urandom_range(1, 10));
      send_item($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.tick  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_SCAN_PERIOD;
    cfg_ch.data   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset periods are huge: a sample and two ticks show the reset display.
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);

    // Zero periods behave as one: every timer fires on every tick.
    load_periods(3'b111, '0, '0, '0, CFG_IDX_UNUSED);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);

    // Short distinct periods so scan and count step at different rates;
    // the colon never toggles with the maximum period.
    load_periods(3'b111, 32'd2, 32'd3, PERIOD_MAX, CFG_IDX_TOP);
    repeat (6) send_item(1'b1);

    // Let the timers run past a small value, then lower the periods below
    // it: the next tick must fire every event and clear the timers.
    load_periods(3'b111, 32'd100, 32'd100, 32'd100, CFG_IDX_UNUSED);
    repeat (4) send_item(1'b1);
    load_periods(3'b111, 32'd2, 32'd2, 32'd2, CFG_IDX_TOP);
    send_item(1'b1);
    send_item(1'b1);

    // Random phases: new periods for a random subset of registers, then a
    // run of items, most with input gaps, some gap-free.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_periods(3'($urandom_range(1, 7)), pick_period(), pick_period(), pick_period(),
                   CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED, CFG_IDX_TOP)));
      run_items(PHASE_ITEMS, $urandom_range(0, 3) != 0);
    end

    // Quiet tail at full rate with short periods.
    load_periods(3'b111, $urandom_range(1, 8), $urandom_range(0, 1), $urandom_range(1, 8),
                 CFG_IDX_UNUSED);
    quiet_tail = 1'b1;
    repeat (TAIL_ITEMS) send_item(1'b1);
    drain();

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
